/* rtl/msb_pkg.sv */
package msb_pkg;

  // Fixed widths of the request and result payload fields
  localparam int unsigned DATA_W = 32;

  // Top-level phase: take requests into the chain, or stream the sorted run out
  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Operation applied to every cell of the chain in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  // Control broadcast from the sequencer to the cells
  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

/* rtl/msb_in_if.sv */
interface msb_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [msb_pkg::DATA_W-1:0]    value;
  logic                                 is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

/* rtl/msb_out_if.sv */
interface msb_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [msb_pkg::DATA_W-1:0]    sorted_value;
  logic                                 end_of_run;
  logic                                 overflow;

  modport source (output valid, output sorted_value, output end_of_run, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input end_of_run, input overflow,
                output ready);
endinterface

/* rtl/merge_sort_buffer_unit.sv */
// merge_sort_buffer_unit: collects a list of signed values and returns it in
// ascending order.
//
// Channels: in_ch carries one value per request, with is_last marking the
// final value of the list. out_ch returns the sorted run, one value per
// request, end_of_run on the final one and overflow on every one when values
// were dropped. Both use valid/ready; a request moves when both are high.
//
// Values enter a chain of DEPTH cells kept in ascending order: each request
// is inserted as it is taken, so loading runs at one request per cycle. Values
// beyond DEPTH are dropped and flagged. The cycle after the last request is
// accepted the first result is offered; the run then leaves at one result per
// cycle while out_ch is ready, the chain shifting one slot towards cell 0 per
// result. in_ch is not ready while a run drains.
//
// A stalled receiver simply holds the chain: the offered result stays in
// cell 0 until taken. Reset empties the chain and clears the overflow flag;
// the cell contents need no reset.
module merge_sort_buffer_unit #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  msb_in_if.sink    in_ch,
  msb_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  msb_pkg::state_t   state;
  msb_pkg::state_t   state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              overflow_seen;
  logic              overflow_seen_next;
  msb_pkg::cell_ctrl_t ctrl;

  logic signed [VALUE_WIDTH-1:0] key_in;
  logic signed [VALUE_WIDTH-1:0] keys [DEPTH];
  logic                          les  [DEPTH];

  logic in_req;
  logic out_req;
  logic full;

  assign in_ch.ready = (state == msb_pkg::ST_LOAD);
  assign in_req      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state == msb_pkg::ST_DRAIN);
  assign out_req     = out_ch.valid && out_ch.ready;
  assign full        = (count == CNT_W'(DEPTH));

  // Read the request as a VALUE_WIDTH-bit two's complement key
  if (VALUE_WIDTH <= msb_pkg::DATA_W) begin : g_key_narrow
    assign key_in = signed'(in_ch.value[VALUE_WIDTH-1:0]);
  end else begin : g_key_wide
    assign key_in = signed'({{(VALUE_WIDTH - msb_pkg::DATA_W){1'b0}}, in_ch.value});
  end

  // Result takes the low bits of the key, zero above the key width
  if (VALUE_WIDTH < msb_pkg::DATA_W) begin : g_out_narrow
    assign out_ch.sorted_value =
      signed'({{(msb_pkg::DATA_W - VALUE_WIDTH){1'b0}}, keys[0]});
  end else if (VALUE_WIDTH == msb_pkg::DATA_W) begin : g_out_equal
    assign out_ch.sorted_value = keys[0];
  end else begin : g_out_wide
    assign out_ch.sorted_value = signed'(keys[0][msb_pkg::DATA_W-1:0]);
  end

  assign out_ch.end_of_run = (count == CNT_W'(1));
  assign out_ch.overflow   = overflow_seen;

  // Chain of cells: each one sees its left and right neighbour
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                          left_le;
    logic signed [VALUE_WIDTH-1:0] left_key;
    logic signed [VALUE_WIDTH-1:0] right_key;

    if (i == 0) begin : g_first
      assign left_le  = 1'b1;
      assign left_key = key_in;
    end else begin : g_mid
      assign left_le  = les[i-1];
      assign left_key = keys[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_key = key_in;
    end else begin : g_inner
      assign right_key = keys[i+1];
    end

    msb_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .INDEX       (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .x         (key_in),
      .left_le   (left_le),
      .left_key  (left_key),
      .right_key (right_key),
      .le        (les[i]),
      .key       (keys[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= msb_pkg::ST_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  always_comb begin
    state_next         = state;
    count_next         = count;
    overflow_seen_next = overflow_seen;
    ctrl.op            = msb_pkg::OP_HOLD;
    unique case (state)
      msb_pkg::ST_LOAD: begin
        if (in_req) begin
          if (full) begin
            // Drop the value, remember it for the run
            overflow_seen_next = 1'b1;
          end else begin
            ctrl.op    = msb_pkg::OP_INSERT;
            count_next = count + CNT_W'(1);
          end
          if (in_ch.is_last) begin
            state_next = msb_pkg::ST_DRAIN;
          end
        end
      end
      msb_pkg::ST_DRAIN: begin
        if (out_req) begin
          // Advance the chain one slot towards cell 0
          ctrl.op    = msb_pkg::OP_SHIFT;
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next         = msb_pkg::ST_LOAD;
            overflow_seen_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = msb_pkg::ST_LOAD;
      end
    endcase
  end

  // Loading and draining never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("request taken while a run drains");

  // A draining run always holds at least one value
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == msb_pkg::ST_DRAIN) |-> (count != '0))
    else $error("drain with empty chain");

  // The end of a run leaves the buffer empty and the flag clear
  a_run_closes: assert property (@(posedge clk) disable iff (rst)
    (out_req && out_ch.end_of_run) |=> (count == '0 && !overflow_seen))
    else $error("buffer not emptied after end of run");

  // Results leave in ascending key order
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    (out_req && !out_ch.end_of_run) |=> ($past(keys[0]) <= keys[0]))
    else $error("results out of order");

endmodule

/* rtl/msb_cell.sv */
// One slot of the sorted chain. Holds one key; the occupied slots stay in
// ascending order from slot 0 upwards.
module msb_cell #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned CNT_W       = 7,
  parameter int unsigned INDEX       = 0
) (
  input  logic                          clk,
  input  msb_pkg::cell_ctrl_t           ctrl,
  input  logic [CNT_W-1:0]              count,
  input  logic signed [VALUE_WIDTH-1:0] x,
  input  logic                          left_le,
  input  logic signed [VALUE_WIDTH-1:0] left_key,
  input  logic signed [VALUE_WIDTH-1:0] right_key,
  output logic                          le,
  output logic signed [VALUE_WIDTH-1:0] key
);

  logic occupied;

  assign occupied = count > CNT_W'(INDEX);
  // Equal keys stay ahead of the new one
  assign le       = occupied && (key <= x);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      msb_pkg::OP_INSERT: begin
        if (!le) begin
          if (left_le) begin
            key <= x;
          end else begin
            key <= left_key;
          end
        end
      end
      msb_pkg::OP_SHIFT: begin
        key <= right_key;
      end
      default: begin
        key <= key;
      end
    endcase
  end

endmodule

/* tb/msb_sort_checker.sv */
module msb_sort_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  msb_in_if    in_ch,
  msb_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [msb_pkg::DATA_W-1:0] word_t;

  typedef struct packed {
    word_t sorted_value;
    logic  end_of_run;
    logic  overflow;
  } sorted_res_t;

  // Values of the list being collected, kept in ascending order as they arrive
  word_t       list_q[$];
  logic        dropped;
  sorted_res_t run_q[$];

  // Insert after any equal value, so ties keep arrival order
  function automatic void place_value(word_t v);
    int pos;
    pos = list_q.size();
    for (int i = 0; i < list_q.size(); i++) begin
      if (list_q[i] > v) begin
        pos = i;
        break;
      end
    end
    list_q.insert(pos, v);
  endfunction

  // Turn the collected list into its sorted run and empty the buffer
  function automatic void close_list();
    sorted_res_t r;
    for (int i = 0; i < list_q.size(); i++) begin
      r.sorted_value = list_q[i];
      r.end_of_run   = (i == list_q.size() - 1);
      r.overflow     = dropped;
      run_q.push_back(r);
    end
    list_q.delete();
    dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    sorted_res_t want;
    if (rst) begin
      list_q.delete();
      run_q.delete();
      dropped    = 1'b0;
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (list_q.size() < DEPTH) place_value(in_ch.value);
        else dropped = 1'b1;
        if (in_ch.is_last) close_list();
      end
      if (out_ch.valid && out_ch.ready) begin
        if (run_q.size() == 0) begin
          $error("sorted_value: expected nothing, got %0d", out_ch.sorted_value);
          fail_count++;
        end else begin
          want = run_q.pop_front();
          if (out_ch.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                   out_ch.sorted_value);
            fail_count++;
          end
          if (out_ch.end_of_run !== want.end_of_run) begin
            $error("end_of_run: expected %0b, got %0b", want.end_of_run, out_ch.end_of_run);
            fail_count++;
          end
          if (out_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_ch.overflow);
            fail_count++;
          end
        end
      end
    end
    pending = run_q.size();
  end

endmodule

/* tb/tb_merge_sort_buffer_unit.sv */
module tb_merge_sort_buffer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned W     = msb_pkg::DATA_W;

  typedef logic signed [W-1:0] word_t;

  localparam word_t V_MAX = {1'b0, {(W-1){1'b1}}};
  localparam word_t V_MIN = ~V_MAX;

  // Stimulus size and pacing
  localparam int REQUESTS    = 470;
  localparam int IDLE_PCT    = 19;
  localparam int CALM_START  = 1000;  // window with no idling on either side
  localparam int CALM_END    = 1600;
  localparam int STALL_AFTER = 100;   // results taken before the long hold-off
  localparam int STALL_LEN   = 400;
  // Drain of a full list plus slack, once nothing is pending
  localparam int SETTLE      = 2 * DEPTH + 20;
  // A correct run needs far less time: every request and every result
  // may be delayed by random idling, each list drains one result at a time and
  // the long hold-off adds its own wait. Allow far more than that.
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst;
  int   cyc;
  int   requests_sent;
  int   results_taken;
  int   fail_count;
  int   pending;
  logic calm;

  msb_in_if  in_ch ();
  msb_out_if out_ch ();

  merge_sort_buffer_unit #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (W)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  msb_sort_checker #(
    .DEPTH (DEPTH)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Count cycles and give up on a hung run
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("merge_sort_buffer_unit verification failed");
      $finish;
    end
  end

  assign calm = (cyc >= CALM_START) && (cyc < CALM_END);

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) results_taken <= results_taken + 1;
  end

  // Mix of extremes, a narrow band that forces ties, and fully random words
  function automatic word_t pick_value();
    word_t v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = V_MIN;
          1:       v = V_MAX;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2: begin
        v = $urandom_range(0, 8);
        v = v - 4;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // Offer one request at the falling edge, idling first at random, and hold it
  // until the block takes it. valid stays high between back-to-back requests.
  task automatic push_request(input word_t v, input logic last);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.value   <= v;
    in_ch.is_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  // Send a whole list of random values, the final one marked
  task automatic send_list(input int len);
    for (int i = 0; i < len; i++) push_request(pick_value(), i == len - 1);
  endtask

  // Receiver: take results with random back-pressure, and once, after enough
  // results, hold off for a long stretch so the block stalls its input side
  initial begin
    bit stalled;
    stalled      = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (!stalled && results_taken >= STALL_AFTER) begin
        stalled = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (STALL_LEN) @(negedge clk);
      end
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Sender and verdict
  initial begin
    int len;
    cyc           = 0;
    requests_sent = 0;
    results_taken = 0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    in_ch.is_last = 1'b0;
    rst           = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Single-value lists at both ends of the range
    push_request(V_MAX, 1'b1);
    push_request(V_MIN, 1'b1);
    // Extremes, zero, minus one and ties within one list
    push_request(V_MAX, 1'b0);
    push_request(V_MIN, 1'b0);
    push_request('0, 1'b0);
    push_request('1, 1'b0);
    push_request(word_t'(5), 1'b0);
    push_request(word_t'(5), 1'b0);
    push_request('1, 1'b0);
    push_request(word_t'(1), 1'b0);
    push_request(V_MIN, 1'b1);
    // Reversed pair
    push_request(word_t'(3), 1'b0);
    push_request(-word_t'(3), 1'b1);
    // All values equal
    repeat (3) push_request(word_t'(7), 1'b0);
    push_request(word_t'(7), 1'b1);

    // Exactly full, one over (the marked value itself is dropped), well over
    send_list(DEPTH);
    send_list(DEPTH + 1);
    send_list(DEPTH + 7);

    // Mostly short lists, now and then a long one that may overflow
    while (requests_sent < REQUESTS) begin
      if ($urandom_range(0, 11) == 0) len = $urandom_range(40, DEPTH + 8);
      else len = $urandom_range(1, 12);
      if (len > REQUESTS - requests_sent) len = REQUESTS - requests_sent;
      send_list(len);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // Wait for every run to drain, then watch for stray results
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (fail_count == 0) begin
      $display("merge_sort_buffer_unit verification clean");
    end else begin
      $display("merge_sort_buffer_unit verification failed");
    end
    $finish;
  end

endmodule
